/* src/tma_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tma_pkg
// Types and fixed constants shared by the moving average controller and
// datapath.
// ----------------------------------------------------------------------------
package tma_pkg;

    localparam int ADC_W   = 10;
    localparam int T_W     = 14;
    localparam int MEAN_W  = 14;
    localparam int WHOLE_W = 10;
    localparam int DIGIT_W = 5;

    localparam int PROD_W = 23;
    localparam logic [PROD_W-1:0] FULL_SCALE_MV = 23'd5000;

    // floor(p / 1023) = (p * MV_RECIP) >> MV_SHIFT for every p below 2^23.
    localparam int RECIP_W  = 24;
    localparam int MV_PROD_W = PROD_W + RECIP_W;
    localparam int MV_SHIFT = 33;
    localparam int MV_W     = 13;
    localparam logic [RECIP_W-1:0] MV_RECIP = 24'd8396809;
    localparam logic signed [T_W-1:0] OFFSET_MV = 14'sd500;

    localparam int T_MAX = 4500;
    localparam int MAG_W = 13;

    // floor(m / 10) = (m * TEN_RECIP) >> TEN_SHIFT for every m below 2^13.
    localparam int TEN_RECIP_W = 14;
    localparam int TEN_PROD_W  = MAG_W + TEN_RECIP_W;
    localparam int TEN_SHIFT   = 17;
    localparam int WMAG_W      = 9;
    localparam int DMAG_W      = 4;
    localparam logic [TEN_RECIP_W-1:0] TEN_RECIP = 14'd13108;
    localparam logic [MAG_W-1:0] TENTHS_PER_DEGREE = 13'd10;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_FILL,
        S_UPD,
        S_DIV1,
        S_DIV2,
        S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic conv;
        logic fill_wr;
        logic upd;
        logic div1;
        logic div2;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_fill;
        logic fill_last;
        logic out_free;
    } t_status;

endpackage
`default_nettype wire

/* src/tma_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tma_ctrl
// Sequencer that walks one transaction through conversion, then either a fill
// sweep or a store update, mean division and the output register.
// ----------------------------------------------------------------------------
module tma_ctrl (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire tma_pkg::t_status i_status,
    output tma_pkg::t_cmd        o_cmd
);

    tma_pkg::t_state r_state;
    tma_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= tma_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            tma_pkg::S_IDLE: begin
                if (i_valid) begin
                    n_state = tma_pkg::S_CONV;
                end
            end
            tma_pkg::S_CONV: begin
                if (i_status.is_fill) begin
                    n_state = tma_pkg::S_FILL;
                end else begin
                    n_state = tma_pkg::S_UPD;
                end
            end
            tma_pkg::S_FILL: begin
                if (i_status.fill_last) begin
                    n_state = tma_pkg::S_IDLE;
                end
            end
            tma_pkg::S_UPD:  n_state = tma_pkg::S_DIV1;
            tma_pkg::S_DIV1: n_state = tma_pkg::S_DIV2;
            tma_pkg::S_DIV2: n_state = tma_pkg::S_OUT;
            tma_pkg::S_OUT: begin
                if (i_status.out_free) begin
                    n_state = tma_pkg::S_IDLE;
                end
            end
            default: n_state = tma_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_ready = 1'b0;
        o_cmd   = '0;
        case (r_state)
            tma_pkg::S_IDLE: begin
                o_ready    = 1'b1;
                o_cmd.load = i_valid;
            end
            tma_pkg::S_CONV: o_cmd.conv    = 1'b1;
            tma_pkg::S_FILL: o_cmd.fill_wr = 1'b1;
            tma_pkg::S_UPD:  o_cmd.upd     = 1'b1;
            tma_pkg::S_DIV1: o_cmd.div1    = 1'b1;
            tma_pkg::S_DIV2: o_cmd.div2    = 1'b1;
            tma_pkg::S_OUT:  o_cmd.out_load = i_status.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

/* src/tma_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tma_dp
// Datapath: code to tenths conversion, sample ring memory with valid bits,
// running sum, mean and digit split by reciprocal multiplication, and the
// output register.
// ----------------------------------------------------------------------------
module tma_dp #(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_mode,
    input  wire logic [tma_pkg::ADC_W-1:0]     i_adc_code,
    input  wire tma_pkg::t_cmd                 i_cmd,
    output tma_pkg::t_status                   o_status,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [tma_pkg::MEAN_W-1:0]  o_mean_tenths,
    output logic signed [tma_pkg::WHOLE_W-1:0] o_whole_degrees,
    output logic signed [tma_pkg::DIGIT_W-1:0] o_tenths_digit
);

    localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SMAG_W = $clog2(DEPTH * tma_pkg::T_MAX + 1);
    localparam int SUM_W  = SMAG_W + 1;
    localparam int SD     = SMAG_W + $clog2(DEPTH);
    localparam longint unsigned MD_L = ((64'd1 << SD) + DEPTH - 1) / DEPTH;
    localparam logic [SD:0] MD = (SD + 1)'(MD_L);
    localparam int QP_W   = SMAG_W + SD + 1;
    localparam logic signed [SUM_W-1:0] DEPTH_S = SUM_W'(DEPTH);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);

    logic signed [tma_pkg::T_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;

    logic                              r_mode;
    logic [tma_pkg::PROD_W-1:0]        r_prod;
    logic signed [tma_pkg::T_W-1:0]    r_t;
    logic signed [tma_pkg::T_W-1:0]    r_old_raw;
    logic                              r_old_vld;
    logic [IDX_W-1:0]                  r_idx;
    logic [IDX_W-1:0]                  r_fill_cnt;
    logic signed [SUM_W-1:0]           r_sum;
    logic                              r_neg;
    logic [QP_W-1:0]                   r_qprod;
    logic [tma_pkg::MAG_W-1:0]         r_mag;
    logic [tma_pkg::TEN_PROD_W-1:0]    r_p10;
    logic                              r_out_valid;
    logic signed [tma_pkg::MEAN_W-1:0]  r_mean;
    logic signed [tma_pkg::WHOLE_W-1:0] r_whole;
    logic signed [tma_pkg::DIGIT_W-1:0] r_digit;

    logic [tma_pkg::MV_PROD_W-1:0]     w_mv_prod;
    logic [tma_pkg::MV_W-1:0]          w_mv;
    logic signed [tma_pkg::T_W-1:0]    w_t;
    logic signed [tma_pkg::T_W-1:0]    w_old;
    logic [SMAG_W-1:0]                 w_abs;
    logic [tma_pkg::MAG_W-1:0]         w_mean_mag;
    logic [tma_pkg::WMAG_W-1:0]        w_whole_mag;
    logic [tma_pkg::MAG_W-1:0]         w_digit_wide;
    logic [tma_pkg::DMAG_W-1:0]        w_digit_mag;
    logic                              w_out_free;

    assign w_mv_prod = tma_pkg::MV_PROD_W'(r_prod) * tma_pkg::MV_PROD_W'(tma_pkg::MV_RECIP);
    assign w_mv      = w_mv_prod[tma_pkg::MV_SHIFT +: tma_pkg::MV_W];
    assign w_t       = $signed({1'b0, w_mv}) - tma_pkg::OFFSET_MV;
    assign w_old     = r_old_vld ? r_old_raw : '0;
    assign w_abs     = r_sum[SUM_W-1] ? SMAG_W'(-r_sum) : SMAG_W'(r_sum);
    assign w_mean_mag  = r_qprod[SD +: tma_pkg::MAG_W];
    assign w_whole_mag = r_p10[tma_pkg::TEN_SHIFT +: tma_pkg::WMAG_W];
    assign w_digit_wide = r_mag - tma_pkg::MAG_W'(w_whole_mag) * tma_pkg::TENTHS_PER_DEGREE;
    assign w_digit_mag  = w_digit_wide[tma_pkg::DMAG_W-1:0];
    assign w_out_free   = !r_out_valid || i_ready;

    assign o_status.is_fill   = r_mode;
    assign o_status.fill_last = (r_fill_cnt == IDX_LAST);
    assign o_status.out_free  = w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_idx       <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.fill_wr) begin
                r_vld[r_fill_cnt] <= 1'b1;
                r_sum             <= SUM_W'(r_t) * DEPTH_S;
            end else if (i_cmd.upd) begin
                r_vld[r_idx] <= 1'b1;
                r_sum        <= r_sum - SUM_W'(w_old) + SUM_W'(r_t);
                r_idx        <= (r_idx == IDX_LAST) ? '0 : r_idx + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            r_mem[r_fill_cnt] <= r_t;
        end else if (i_cmd.upd) begin
            r_mem[r_idx] <= r_t;
        end
        if (i_cmd.load) begin
            r_old_raw <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode    <= i_mode;
            r_prod    <= tma_pkg::PROD_W'(i_adc_code) * tma_pkg::FULL_SCALE_MV;
            r_old_vld <= r_vld[r_idx];
        end
        if (i_cmd.conv) begin
            r_t        <= w_t;
            r_fill_cnt <= '0;
        end else if (i_cmd.fill_wr) begin
            r_fill_cnt <= r_fill_cnt + 1'b1;
        end
        if (i_cmd.div1) begin
            r_neg   <= r_sum[SUM_W-1];
            r_qprod <= QP_W'(w_abs) * QP_W'(MD);
        end
        if (i_cmd.div2) begin
            r_mag <= w_mean_mag;
            r_p10 <= tma_pkg::TEN_PROD_W'(w_mean_mag) * tma_pkg::TEN_PROD_W'(tma_pkg::TEN_RECIP);
        end
        if (i_cmd.out_load) begin
            if (r_neg) begin
                r_mean  <= -$signed({1'b0, r_mag});
                r_whole <= -$signed({1'b0, w_whole_mag});
                r_digit <= -$signed({1'b0, w_digit_mag});
            end else begin
                r_mean  <= $signed({1'b0, r_mag});
                r_whole <= $signed({1'b0, w_whole_mag});
                r_digit <= $signed({1'b0, w_digit_mag});
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_mean_tenths   = r_mean;
    assign o_whole_degrees = r_whole;
    assign o_tenths_digit  = r_digit;

endmodule
`default_nettype wire

/* src/temperature_moving_average.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// temperature_moving_average
// Boxcar moving average of converter readings in tenths of a degree.
// ----------------------------------------------------------------------------
// The input channel (i_valid / o_ready) carries a mode bit and a 10-bit
// converter code. A sample transaction replaces the oldest of DEPTH stored
// readings and produces one result transaction on the output channel
// (o_valid / i_ready): the window mean, whole degrees and a signed tenths
// digit. A fill transaction writes its reading into every slot and produces
// no result.
// After acceptance a sample passes the states CONV, UPD, DIV1, DIV2 and OUT,
// and the next transaction is accepted once the output register is loaded.
// The conversion, the store update and the two reciprocal multiplications of
// the mean and its split each have their own state of the sequencer.
// A fill passes CONV and then FILL, which writes one slot per cycle through
// the ring memory write port.
// Reset clears the ring index, the running sum, the output valid flag and the
// valid bit of every slot, so all slots read as zero after reset.
// When the receiver stalls, the result waits in the output register while the
// next transaction is accepted; a following result waits until it is taken.
// ----------------------------------------------------------------------------
module temperature_moving_average #(
    parameter int DEPTH = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_mode,
    input  wire logic [tma_pkg::ADC_W-1:0]     i_adc_code,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic signed [tma_pkg::MEAN_W-1:0]  o_mean_tenths,
    output logic signed [tma_pkg::WHOLE_W-1:0] o_whole_degrees,
    output logic signed [tma_pkg::DIGIT_W-1:0] o_tenths_digit
);

    tma_pkg::t_cmd    w_cmd;
    tma_pkg::t_status w_status;

    tma_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    tma_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_mode          (i_mode),
        .i_adc_code      (i_adc_code),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_mean_tenths   (o_mean_tenths),
        .o_whole_degrees (o_whole_degrees),
        .o_tenths_digit  (o_tenths_digit)
    );

endmodule
`default_nettype wire

/* src/tma_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tma_checker
// Port-level checks of the moving average block, bound to the top level.
// ----------------------------------------------------------------------------
module tma_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic                          o_ready,
    input  wire logic                          o_valid,
    input  wire logic                          i_ready,
    input  wire logic signed [tma_pkg::MEAN_W-1:0]  o_mean_tenths,
    input  wire logic signed [tma_pkg::WHOLE_W-1:0] o_whole_degrees,
    input  wire logic signed [tma_pkg::DIGIT_W-1:0] o_tenths_digit
);

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("Output valid is set after reset.");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("A transaction was accepted while another one is in work.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_mean_tenths))
        else $error("A stalled result changed.");

    a_split_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (16'(o_whole_degrees) * 16'sd10 + 16'(o_tenths_digit))
                    == 16'(o_mean_tenths))
        else $error("Whole degrees and tenths digit do not rebuild the mean.");

    a_ranges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_mean_tenths >= -14'sd500 && o_mean_tenths <= 14'sd4500
                    && o_tenths_digit >= -5'sd9 && o_tenths_digit <= 5'sd9)
        else $error("A result lies outside its range.");

endmodule

bind temperature_moving_average tma_checker u_tma_checker (.*);
`default_nettype wire
